[design/fraction_add_sub_reduce_defines.svh]
// Assertion macros used by the fraction add/subtract/reduce datapath.
`ifndef FRACTION_ADD_SUB_REDUCE_DEFINES_SVH
`define FRACTION_ADD_SUB_REDUCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FRAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FRAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction unit: next-cycle check failed");

`endif

[design/frac_pkg.sv]
// Shared types and constants of the fraction add/subtract/reduce unit.
package frac_pkg;

  // Fixed result field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // Operation codes; any code other than add or subtract acts as make
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MAKE = 2'd2;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MUL_AD,
    CMD_MUL_CB,
    CMD_MUL_BD,
    CMD_MAG,
    CMD_COMBINE,
    CMD_DIV_GCD,
    CMD_DIV_NUM,
    CMD_DIV_DEN,
    CMD_OUT
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err;       // zero denominator in the loaded beat
    logic make;      // loaded operation is make
    logic y_zero;    // Euclid divisor has reached zero
    logic div_done;  // divider finished this cycle
  } dp_stat_t;

endpackage

[design/frac_in_if.sv]
// Input channel: operation and two signed fractions with valid/ready.
interface frac_in_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic signed [W-1:0] first_num;
  logic signed [W-1:0] first_den;
  logic signed [W-1:0] second_num;
  logic signed [W-1:0] second_den;

  modport source (
    output valid, operation, first_num, first_den, second_num, second_den,
    input  ready
  );
  modport sink (
    input  valid, operation, first_num, first_den, second_num, second_den,
    output ready
  );
endinterface

[design/frac_out_if.sv]
// Result channel: reduced fraction and status with valid/ready.
interface frac_out_if ();
  logic                              valid;
  logic                              ready;
  logic signed [frac_pkg::NUM_W-1:0] result_num;
  logic [frac_pkg::DEN_W-1:0]        result_den;
  logic                              status;

  modport source (
    output valid, result_num, result_den, status,
    input  ready
  );
  modport sink (
    input  valid, result_num, result_den, status,
    output ready
  );
endinterface

[design/frac_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module frac_div #(
  parameter int WIDE = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [WIDE-1:0] dividend,
  input  logic [WIDE-1:0] divisor,
  output logic            done,
  output logic [WIDE-1:0] quotient,
  output logic [WIDE-1:0] remainder
);
  localparam int CW = $clog2(WIDE + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [WIDE-1:0] rem_r;
  logic [WIDE-1:0] quo_r;
  logic [WIDE-1:0] dvs_r;
  logic [WIDE:0]   shifted;
  logic [WIDE:0]   trial;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_r, quo_r[WIDE-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDE);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // remainder stays below the divisor, so WIDE bits hold it
        rem_r <= trial[WIDE] ? shifted[WIDE-1:0] : trial[WIDE-1:0];
        quo_r <= {quo_r[WIDE-2:0], ~trial[WIDE]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[design/frac_dp.sv]
// Datapath: operand registers, shared multiplier, sign/magnitude, GCD and division.
`include "fraction_add_sub_reduce_defines.svh"

module frac_dp #(
  parameter int W = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  frac_pkg::dp_cmd_t                 cmd,
  output frac_pkg::dp_stat_t                stat,
  input  logic [1:0]                        operation,
  input  logic signed [W-1:0]               first_num,
  input  logic signed [W-1:0]               first_den,
  input  logic signed [W-1:0]               second_num,
  input  logic signed [W-1:0]               second_den,
  output logic signed [frac_pkg::NUM_W-1:0] result_num,
  output logic [frac_pkg::DEN_W-1:0]        result_den,
  output logic                              status
);
  import frac_pkg::*;

  localparam int WIDE = 2 * W;
  localparam int EXTW = (WIDE > NUM_W) ? WIDE : NUM_W;

  // Operand registers
  logic [1:0]          op_r;
  logic signed [W-1:0] a_r, b_r, c_r, d_r;

  // Products
  logic signed [W-1:0]    mul_x, mul_y;
  logic signed [WIDE-1:0] prod;
  logic signed [WIDE-1:0] p_r, q_r, den_r;

  // Sign and magnitude
  logic signed [WIDE-1:0] p_src, q_src, den_src;
  logic                   p_neg_c, q_neg_c;
  logic [WIDE-1:0]        pm_c, qm_c, dm_c;
  logic [WIDE-1:0]        pm_r, qm_r, dm_r;
  logic                   p_neg_r, q_neg_r, den_neg_r, num_neg_r;

  // Numerator combine
  logic [WIDE-1:0] sum_c, qp_c, nm_c;
  logic [WIDE:0]   pq_c;
  logic            num_neg_c;
  logic [WIDE-1:0] nm_r;

  // Euclid and division
  logic [WIDE-1:0] x_r, y_r;
  logic [WIDE-1:0] nq_r, dq_r;
  dp_cmd_t         div_sel_r;
  logic            div_start;
  logic [WIDE-1:0] div_dividend, div_divisor;
  logic            div_done;
  logic [WIDE-1:0] div_quo, div_rem;

  // Output formatting
  logic [EXTW-1:0]                 nq_ext, num_ext, dq_ext;
  logic signed [NUM_W-1:0]         result_num_r;
  logic [DEN_W-1:0]                result_den_r;
  logic                            status_r;
  logic                            make, err;

  // Decode of the loaded beat
  assign make = !(op_r inside {OP_ADD, OP_SUB});
  assign err  = (b_r == '0) || (!make && d_r == '0);

  // Shared signed multiplier
  always_comb begin
    case (cmd)
      CMD_MUL_CB: begin
        mul_x = c_r;
        mul_y = b_r;
      end
      CMD_MUL_BD: begin
        mul_x = b_r;
        mul_y = d_r;
      end
      default: begin
        mul_x = a_r;
        mul_y = d_r;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  // Sign and magnitude of the two numerator terms and the denominator;
  // make feeds a/b straight through with a zero second term
  assign p_src   = make ? WIDE'(a_r) : p_r;
  assign q_src   = make ? '0 : q_r;
  assign den_src = make ? WIDE'(b_r) : den_r;
  assign p_neg_c = p_src[WIDE-1];
  always_comb begin
    if (make) begin
      q_neg_c = p_neg_c;
    end else if (op_r == OP_SUB) begin
      q_neg_c = !q_src[WIDE-1] && (q_src != '0);
    end else begin
      q_neg_c = q_src[WIDE-1];
    end
  end
  assign pm_c = p_src[WIDE-1]   ? WIDE'(-p_src)   : WIDE'(p_src);
  assign qm_c = q_src[WIDE-1]   ? WIDE'(-q_src)   : WIDE'(q_src);
  assign dm_c = den_src[WIDE-1] ? WIDE'(-den_src) : WIDE'(den_src);

  // Signed-magnitude add of the two terms
  assign sum_c = pm_r + qm_r;
  assign pq_c  = {1'b0, pm_r} - {1'b0, qm_r};
  assign qp_c  = qm_r - pm_r;
  always_comb begin
    if (p_neg_r == q_neg_r) begin
      nm_c      = sum_c;
      num_neg_c = p_neg_r;
    end else if (!pq_c[WIDE]) begin
      nm_c      = pq_c[WIDE-1:0];
      num_neg_c = p_neg_r;
    end else begin
      nm_c      = qp_c;
      num_neg_c = q_neg_r;
    end
  end

  // Divider operands: Euclid step x % y, then both terms over the gcd in x
  assign div_start = cmd inside {CMD_DIV_GCD, CMD_DIV_NUM, CMD_DIV_DEN};
  always_comb begin
    case (cmd)
      CMD_DIV_GCD: begin
        div_dividend = x_r;
        div_divisor  = y_r;
      end
      CMD_DIV_NUM: begin
        div_dividend = nm_r;
        div_divisor  = x_r;
      end
      default: begin
        div_dividend = dm_r;
        div_divisor  = x_r;
      end
    endcase
  end

  frac_div #(.WIDE(WIDE)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sign goes to the numerator; fields are cut to their fixed widths
  assign nq_ext  = EXTW'(nq_r);
  assign num_ext = (num_neg_r != den_neg_r) ? (~nq_ext + EXTW'(1)) : nq_ext;
  assign dq_ext  = EXTW'(dq_r);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r <= operation;
        a_r  <= first_num;
        b_r  <= first_den;
        c_r  <= second_num;
        d_r  <= second_den;
      end
      CMD_MUL_AD: p_r   <= prod;
      CMD_MUL_CB: q_r   <= prod;
      CMD_MUL_BD: den_r <= prod;
      CMD_MAG: begin
        pm_r      <= pm_c;
        qm_r      <= qm_c;
        dm_r      <= dm_c;
        p_neg_r   <= p_neg_c;
        q_neg_r   <= q_neg_c;
        den_neg_r <= den_src[WIDE-1];
      end
      CMD_COMBINE: begin
        nm_r      <= nm_c;
        num_neg_r <= num_neg_c;
        x_r       <= nm_c;
        y_r       <= dm_r;
      end
      CMD_DIV_GCD, CMD_DIV_NUM, CMD_DIV_DEN: div_sel_r <= cmd;
      CMD_OUT: begin
        if (err) begin
          result_num_r <= '0;
          result_den_r <= DEN_W'(1);
          status_r     <= 1'b1;
        end else begin
          result_num_r <= $signed(num_ext[NUM_W-1:0]);
          result_den_r <= dq_ext[DEN_W-1:0];
          status_r     <= 1'b0;
        end
      end
      default: ;
    endcase

    // Divider results
    if (div_done) begin
      case (div_sel_r)
        CMD_DIV_GCD: begin
          x_r <= y_r;
          y_r <= div_rem;
        end
        CMD_DIV_NUM: nq_r <= div_quo;
        CMD_DIV_DEN: dq_r <= div_quo;
        default: ;
      endcase
    end
  end

  assign stat.err      = err;
  assign stat.make     = make;
  assign stat.y_zero   = (y_r == '0);
  assign stat.div_done = div_done;

  assign result_num = result_num_r;
  assign result_den = result_den_r;
  assign status     = status_r;

  // Checks
  `FRAC_ASSERT_IMP(a_div_by_nonzero, div_start, div_divisor != '0)
  `FRAC_ASSERT_NXT(a_euclid_shrinks, div_done && div_sel_r == CMD_DIV_GCD, y_r < x_r)
  `FRAC_ASSERT_IMP(a_reduced_den_pos, cmd == CMD_OUT && !err, dq_r != '0)

endmodule

[design/frac_ctrl.sv]
// Controller: sequences multiply, combine, Euclid loop, division and output.
module frac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output frac_pkg::dp_cmd_t  cmd,
  input  frac_pkg::dp_stat_t stat
);
  import frac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_AD,
    S_MUL_CB,
    S_MUL_BD,
    S_MAG,
    S_COMB,
    S_GCD_TEST,
    S_GCD_GO,
    S_GCD_WAIT,
    S_NUM_GO,
    S_NUM_WAIT,
    S_DEN_GO,
    S_DEN_WAIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  // Output slot is free when empty or drained this cycle
  assign out_free = !out_valid_r || out_ready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err) begin
          state_nxt = S_OUT;
        end else if (stat.make) begin
          state_nxt = S_MAG;
        end else begin
          state_nxt = S_MUL_AD;
        end
      end
      S_MUL_AD: begin
        cmd       = CMD_MUL_AD;
        state_nxt = S_MUL_CB;
      end
      S_MUL_CB: begin
        cmd       = CMD_MUL_CB;
        state_nxt = S_MUL_BD;
      end
      S_MUL_BD: begin
        cmd       = CMD_MUL_BD;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd       = CMD_MAG;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd       = CMD_COMBINE;
        state_nxt = S_GCD_TEST;
      end
      S_GCD_TEST: begin
        state_nxt = stat.y_zero ? S_NUM_GO : S_GCD_GO;
      end
      S_GCD_GO: begin
        cmd       = CMD_DIV_GCD;
        state_nxt = S_GCD_WAIT;
      end
      S_GCD_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_GCD_TEST;
        end
      end
      S_NUM_GO: begin
        cmd       = CMD_DIV_NUM;
        state_nxt = S_NUM_WAIT;
      end
      S_NUM_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_DEN_GO;
        end
      end
      S_DEN_GO: begin
        cmd       = CMD_DIV_DEN;
        state_nxt = S_DEN_WAIT;
      end
      S_DEN_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
      if (cmd == CMD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

[design/fraction_add_sub_reduce.sv]
// Top level of the fraction add/subtract/reduce unit.
//
// in_ch takes one beat: an operation (add, subtract, make) and two signed
// fractions a/b and c/d of OPERAND_WIDTH bits. out_ch returns one beat per
// input: the sum, difference or a/b alone in lowest terms, sign on the
// numerator, denominator positive, and a status bit. A zero denominator
// gives status 1 with 0/1.
// Beats are taken one at a time, and the next beat is accepted no sooner
// than the first edge at which the previous result can be taken. Every
// remainder and both final quotients go through one shared divider that
// makes one bit per cycle over 2*W bits, with W = OPERAND_WIDTH, so the
// time per item grows with the number of Euclid steps; make skips the three
// multiplies and a zero-denominator item goes straight to the output.
// After reset no beat is pending, in_ch is ready and out_ch is empty.
// The result sits in an output register; a new beat is accepted while it
// waits, and a stalled receiver only holds the next result back at its end.
module fraction_add_sub_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  frac_in_if.sink    in_ch,
  frac_out_if.source out_ch
);
  import frac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  frac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic
  frac_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (in_ch.operation),
    .first_num  (in_ch.first_num),
    .first_den  (in_ch.first_den),
    .second_num (in_ch.second_num),
    .second_den (in_ch.second_den),
    .result_num (out_ch.result_num),
    .result_den (out_ch.result_den),
    .status     (out_ch.status)
  );

endmodule
